@@ rtl/vls_pkg.sv @@
// shared types and defaults for the vector length scaler
// no dependencies; used by every module under rtl
`default_nettype none

package vls_pkg;

    localparam int WIDTH_DEFAULT     = 32;
    localparam int FRAC_BITS_DEFAULT = 16;

    typedef enum logic [1:0] {
        CMD_NORM  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLAMP = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    // per-transaction control travelling alongside the lanes
    typedef struct packed {
        logic valid;
        logic scale;
    } ctrl_t;

endpackage

`default_nettype wire

@@ rtl/vls_front.sv @@
// front end: magnitudes, squared length, scale decision and per-lane square of m*L
// depends on vls_pkg
`default_nettype none

module vls_front #(
    parameter int WIDTH     = vls_pkg::WIDTH_DEFAULT,
    parameter int FRAC_BITS = vls_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire logic [1:0]               command,
    input  wire logic [2:0][WIDTH-1:0]    comp,
    input  wire logic [WIDTH-2:0]         target_length,
    output vls_pkg::ctrl_t                ctrl,
    output logic [2*WIDTH-1:0]            sum_sq,
    output logic [2:0][4*WIDTH-1:0]       bound,
    output logic [2:0][WIDTH-1:0]         raw
);

    localparam int W  = WIDTH;
    localparam int SW = 2 * WIDTH;
    localparam int AW = 4 * WIDTH;

    // stage 1
    logic                  v1_reg;
    logic [1:0]            cmd1_reg;
    logic [2:0][W-1:0]     mag1_reg;
    logic [2:0][W-1:0]     raw1_reg;
    logic [W-1:0]          len1_reg;
    // stage 2
    logic                  v2_reg;
    logic [1:0]            cmd2_reg;
    logic [2:0][SW-1:0]    sq2_reg;
    logic [2:0][SW-1:0]    ml2_reg;
    logic [SW-1:0]         l2_2_reg;
    logic [2:0][W-1:0]     raw2_reg;
    // stage 3
    vls_pkg::ctrl_t        c3_reg;
    logic [SW-1:0]         s3_reg;
    logic [2:0][SW-1:0]    hh3_reg;
    logic [2:0][SW-1:0]    hl3_reg;
    logic [2:0][SW-1:0]    ll3_reg;
    logic [2:0][W-1:0]     raw3_reg;
    // stage 4
    vls_pkg::ctrl_t        c4_reg;
    logic [SW-1:0]         s4_reg;
    logic [2:0][AW-1:0]    a4_reg;
    logic [2:0][W-1:0]     raw4_reg;

    logic [SW-1:0]         s3_next;
    logic                  scale3_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else
        begin
            v1_reg       <= accept;
            v2_reg       <= v1_reg;
            c3_reg.valid <= v2_reg;
            c3_reg.scale <= scale3_next;
            c4_reg       <= c3_reg;
        end
    end

    assign s3_next = sq2_reg[0] + sq2_reg[1] + sq2_reg[2];

    always_comb
    begin
        scale3_next = 1'b0;
        case (vls_pkg::cmd_t'(cmd2_reg))
            vls_pkg::CMD_NORM:  scale3_next = 1'b1;
            vls_pkg::CMD_SET:   scale3_next = 1'b1;
            vls_pkg::CMD_CLAMP: scale3_next = (s3_next > l2_2_reg);
            default:            scale3_next = 1'b0;
        endcase
        if (s3_next == '0)
        begin
            scale3_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg <= command;
        len1_reg <= (vls_pkg::cmd_t'(command) == vls_pkg::CMD_NORM)
                    ? (W'(1) << FRAC_BITS) : {1'b0, target_length};
        for (int i = 0; i < 3; i++)
        begin
            raw1_reg[i] <= comp[i];
            mag1_reg[i] <= comp[i][W-1] ? (~comp[i] + W'(1)) : comp[i];
        end

        cmd2_reg <= cmd1_reg;
        l2_2_reg <= SW'(len1_reg) * SW'(len1_reg);
        for (int i = 0; i < 3; i++)
        begin
            raw2_reg[i] <= raw1_reg[i];
            sq2_reg[i]  <= SW'(mag1_reg[i]) * SW'(mag1_reg[i]);
            ml2_reg[i]  <= SW'(mag1_reg[i]) * SW'(len1_reg);
        end

        // (m*L)^2 cut into partial products of half width
        s3_reg <= s3_next;
        for (int i = 0; i < 3; i++)
        begin
            raw3_reg[i] <= raw2_reg[i];
            hh3_reg[i]  <= SW'(ml2_reg[i][SW-1:W]) * SW'(ml2_reg[i][SW-1:W]);
            hl3_reg[i]  <= SW'(ml2_reg[i][SW-1:W]) * SW'(ml2_reg[i][W-1:0]);
            ll3_reg[i]  <= SW'(ml2_reg[i][W-1:0]) * SW'(ml2_reg[i][W-1:0]);
        end

        s4_reg <= s3_reg;
        for (int i = 0; i < 3; i++)
        begin
            raw4_reg[i] <= raw3_reg[i];
            a4_reg[i]   <= (AW'(hh3_reg[i]) << SW) + (AW'(hl3_reg[i]) << (W + 1))
                           + AW'(ll3_reg[i]);
        end
    end

    assign ctrl   = c4_reg;
    assign sum_sq = s4_reg;
    assign bound  = a4_reg;
    assign raw    = raw4_reg;

endmodule

`default_nettype wire

@@ rtl/vls_lane.sv @@
// one lane: pipelined bit search for the largest q with q*q*s <= (m*L)^2
// depends on vls_pkg for parameter defaults
`default_nettype none

module vls_lane #(
    parameter int WIDTH = vls_pkg::WIDTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic [2*WIDTH-1:0]     s_in,
    input  wire logic [4*WIDTH-1:0]     a_in,
    input  wire logic [WIDTH-1:0]       raw_in,
    output logic [WIDTH-1:0]            q_out,
    output logic [WIDTH-1:0]            raw_out
);

    localparam int W  = WIDTH;
    localparam int SW = 2 * WIDTH;
    localparam int AW = 4 * WIDTH;
    localparam int PW = 4 * WIDTH + 1;
    localparam int QW = 3 * WIDTH;

    // running q*q*s and q*s, kept so each step is shifts and adds
    logic [PW-1:0] p_reg  [1:W-1];
    logic [QW-1:0] qs_reg [1:W-1];
    logic [SW-1:0] s_reg  [1:W-1];
    logic [AW-1:0] a_reg  [1:W-1];
    logic [W-1:0]  q_reg  [1:W];
    logic [W-1:0]  r_reg  [1:W];

    for (genvar k = 0; k < W; k++)
    begin : g_step
        localparam int B = W - 1 - k;
        logic [PW-1:0] p_cur;
        logic [QW-1:0] qs_cur;
        logic [SW-1:0] s_cur;
        logic [AW-1:0] a_cur;
        logic [W-1:0]  q_cur;
        logic [W-1:0]  r_cur;
        logic [PW-1:0] cand;
        logic          fits;

        if (k == 0)
        begin : g_first
            assign p_cur  = '0;
            assign qs_cur = '0;
            assign s_cur  = s_in;
            assign a_cur  = a_in;
            assign q_cur  = '0;
            assign r_cur  = raw_in;
        end
        else
        begin : g_rest
            assign p_cur  = p_reg[k];
            assign qs_cur = qs_reg[k];
            assign s_cur  = s_reg[k];
            assign a_cur  = a_reg[k];
            assign q_cur  = q_reg[k];
            assign r_cur  = r_reg[k];
        end

        // (q + 2^b)^2 s = q^2 s + 2^(b+1) q s + 2^(2b) s
        assign cand = p_cur + (PW'(qs_cur) << (B + 1)) + (PW'(s_cur) << (2 * B));
        assign fits = (cand <= PW'(a_cur));

        always_ff @(posedge clk)
        begin
            q_reg[k+1] <= fits ? (q_cur | (W'(1) << B)) : q_cur;
            r_reg[k+1] <= r_cur;
        end

        if (k < W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                p_reg[k+1]  <= fits ? cand : p_cur;
                qs_reg[k+1] <= fits ? (qs_cur + (QW'(s_cur) << B)) : qs_cur;
                s_reg[k+1]  <= s_cur;
                a_reg[k+1]  <= a_cur;
            end
        end
    end

    assign q_out   = q_reg[W];
    assign raw_out = r_reg[W];

endmodule

`default_nettype wire

@@ rtl/vls_merge.sv @@
// merge stage: saturation, sign restore and pass-through select into the output register
// depends on vls_pkg
`default_nettype none

module vls_merge #(
    parameter int WIDTH = vls_pkg::WIDTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  vls_pkg::ctrl_t              ctrl,
    input  wire logic [2:0][WIDTH-1:0]  q,
    input  wire logic [2:0][WIDTH-1:0]  raw,
    output logic                        done,
    output logic [2:0][WIDTH-1:0]       res,
    output logic                        scaled
);

    localparam int W = WIDTH;
    localparam logic [W-1:0] MAG_MAX = {1'b0, {(W-1){1'b1}}};

    logic                 done_reg;
    logic                 scaled_reg;
    logic [2:0][W-1:0]    res_reg;
    logic [2:0][W-1:0]    res_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [W-1:0] m;
            m = (q[i] > MAG_MAX) ? MAG_MAX : q[i];
            if (!ctrl.scale)
            begin
                res_next[i] = raw[i];
            end
            else
            begin
                res_next[i] = raw[i][W-1] ? (~m + W'(1)) : m;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            scaled_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= ctrl.valid;
            scaled_reg <= ctrl.valid & ctrl.scale;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign scaled = scaled_reg;
    assign res    = res_reg;

endmodule

`default_nettype wire

@@ rtl/vector_length_scaler.sv @@
// path: the front stages, the per-lane bit search and the merge register lie between the accepting edge and done
// throughput: one transaction per cycle; busy is never raised
// the per-lane bit search resolves one quotient bit per stage
// reset: rst_n asynchronous active low clears every valid flag and done
// depends on vls_pkg, vls_front, vls_lane, vls_merge
`default_nettype none

module vector_length_scaler #(
    parameter int WIDTH     = vls_pkg::WIDTH_DEFAULT,
    parameter int FRAC_BITS = vls_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              command,
    input  wire logic signed [WIDTH-1:0] in_x,
    input  wire logic signed [WIDTH-1:0] in_y,
    input  wire logic signed [WIDTH-1:0] in_z,
    input  wire logic [WIDTH-2:0]        target_length,
    output logic                         done,
    output logic signed [WIDTH-1:0]      out_x,
    output logic signed [WIDTH-1:0]      out_y,
    output logic signed [WIDTH-1:0]      out_z,
    output logic                         was_scaled
);

    localparam int W   = WIDTH;
    localparam int LAT = WIDTH + 5;

    // the pipeline never stalls, so every start is taken
    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    logic [2:0][W-1:0]      comp;
    vls_pkg::ctrl_t         front_ctrl;
    logic [2*W-1:0]         sum_sq;
    logic [2:0][4*W-1:0]    bound;
    logic [2:0][W-1:0]      front_raw;
    logic [2:0][W-1:0]      lane_q;
    logic [2:0][W-1:0]      lane_raw;
    logic [2:0][W-1:0]      res;

    assign comp[0] = in_x;
    assign comp[1] = in_y;
    assign comp[2] = in_z;

    vls_front #(
        .WIDTH     (WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .command       (command),
        .comp          (comp),
        .target_length (target_length),
        .ctrl          (front_ctrl),
        .sum_sq        (sum_sq),
        .bound         (bound),
        .raw           (front_raw)
    );

    // three identical lanes, one per component, sharing the squared length
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vls_lane #(
            .WIDTH (WIDTH)
        ) u_lane (
            .clk     (clk),
            .s_in    (sum_sq),
            .a_in    (bound[i]),
            .raw_in  (front_raw[i]),
            .q_out   (lane_q[i]),
            .raw_out (lane_raw[i])
        );
    end

    // control follows the lanes through the same number of stages
    vls_pkg::ctrl_t ctrl_reg [1:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= W; k++)
            begin
                ctrl_reg[k] <= '0;
            end
        end
        else
        begin
            ctrl_reg[1] <= front_ctrl;
            for (int k = 2; k <= W; k++)
            begin
                ctrl_reg[k] <= ctrl_reg[k-1];
            end
        end
    end

    vls_merge #(
        .WIDTH (WIDTH)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl_reg[W]),
        .q      (lane_q),
        .raw    (lane_raw),
        .done   (done),
        .res    (res),
        .scaled (was_scaled)
    );

    assign out_x = res[0];
    assign out_y = res[1];
    assign out_z = res[2];

`ifndef SYNTHESIS
    // every accepted transaction returns with done at the end of the full pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("transaction result missing at fixed latency");

    // a result with no rescaling carries the original vector
    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        done && !was_scaled |-> out_x == $past(in_x, LAT) && out_y == $past(in_y, LAT)
                                && out_z == $past(in_z, LAT))
        else $error("pass-through result differs from input");

    // scaled flag only accompanies a result
    a_scaled_done: assert property (@(posedge clk) disable iff (!rst_n)
        was_scaled |-> done)
        else $error("was_scaled without done");
`endif

endmodule

`default_nettype wire
